>>> rtl/bpool_pkg.sv
// Types and codes shared by the buffer pool files.
`timescale 1ns / 1ps
`default_nettype none
package bpool_pkg;

   localparam int unsigned KindW    = 2;
   localparam int unsigned HandleW  = 3;
   localparam int unsigned OwnerW   = 4;
   localparam int unsigned TimeW    = 32;
   localparam int unsigned TimeoutW = 16;
   localparam logic [TimeoutW-1:0] TimeoutReset = 16'd500;

   typedef enum logic [KindW-1:0] {
      KIND_OBTAIN  = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_ARM     = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   typedef enum logic [KindW-1:0] {
      RES_GRANTED = 2'd0,
      RES_FULL    = 2'd1,
      RES_DONE    = 2'd2,
      RES_NOTICE  = 2'd3
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_READ  = 2'd1,
      ST_CHECK = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

endpackage
`default_nettype wire

>>> rtl/bpool_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bpool_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/buffer_pool_with_ack_timeout_core.sv
// Buffer descriptor pool with acknowledgement timeout: top level.
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  req_kind, req_handle, req_owner
//  rsp_     out        rsp_valid/rsp_stall  rsp_result_kind, rsp_handle_res,
//                                           rsp_owner_res, rsp_last
//  csr_     in         csr_write_enable     csr_write_data (ack timeout)
//
// Obtain, release and arm are handled directly in the idle state.
// A tick advances the time counter and scans each descriptor: a read of the
// owner and arm-time memories (ST_READ), then a compare (ST_CHECK); done follows.
// A notice or done held up by rsp_stall holds the scan at that descriptor.
// Synchronous reset frees every descriptor and clears the time counter.
`timescale 1ns / 1ps
`default_nettype none
module buffer_pool_with_ack_timeout_core
   import bpool_pkg::*;
#(
   parameter int unsigned NUM_BUFFERS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [KindW-1:0]    req_kind,
   input  wire logic [HandleW-1:0]  req_handle,
   input  wire logic [OwnerW-1:0]   req_owner,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [KindW-1:0]    rsp_result_kind,
   output      logic [HandleW-1:0]  rsp_handle_res,
   output      logic [OwnerW-1:0]   rsp_owner_res,
   output      logic                rsp_last,
   input  wire logic                csr_write_enable,
   input  wire logic [TimeoutW-1:0] csr_write_data
);

   localparam int unsigned IdxW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_BUFFERS - 1);

   state_type             state_ff, state_in;
   logic [IdxW-1:0]       idx_ff, idx_in;
   logic [TimeW-1:0]      time_now_ff, time_now_in;
   logic [TimeoutW-1:0]   timeout_ff;
   logic [NUM_BUFFERS-1:0] free_ff, free_in;
   logic [NUM_BUFFERS-1:0] wait_ff, wait_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KindW-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [HandleW-1:0]    rsp_handle_ff, rsp_handle_in;
   logic [OwnerW-1:0]     rsp_owner_ff, rsp_owner_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  accept;
   kind_type              kind;
   logic [IdxW-1:0]       hidx;
   logic                  h_ok;
   logic                  any_free;
   logic [IdxW-1:0]       grant_idx;
   logic [TimeW-1:0]      age;
   logic                  hit;

   logic                  owner_we;
   logic                  time_we;
   logic                  rd_en;
   logic [OwnerW-1:0]     owner_rdata;
   logic [TimeW-1:0]      time_rdata;

   bpool_ram #(
      .WIDTH (OwnerW),
      .DEPTH (NUM_BUFFERS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (owner_we),
      .wr_addr (grant_idx),
      .wr_data (req_owner),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (owner_rdata)
   );

   bpool_ram #(
      .WIDTH (TimeW),
      .DEPTH (NUM_BUFFERS)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (time_we),
      .wr_addr (hidx),
      .wr_data (time_now_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (time_rdata)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign kind      = kind_type'(req_kind);
   assign hidx      = IdxW'(req_handle);
   assign h_ok      = 32'(req_handle) < 32'(NUM_BUFFERS);
   assign any_free  = |free_ff;
   assign age       = time_now_ff - time_rdata;
   assign hit       = wait_ff[idx_ff] && (age > TimeW'(timeout_ff));

   // lowest free descriptor
   always_comb begin
      grant_idx = '0;
      for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            grant_idx = IdxW'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && kind == KIND_TICK) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (hit && !out_free) begin
               state_in = ST_CHECK;
            end else if (idx_ff == LastIdx) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in        = idx_ff;
      time_now_in   = time_now_ff;
      free_in       = free_ff;
      wait_in       = wait_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_last_in   = rsp_last_ff;
      owner_we      = 1'b0;
      time_we       = 1'b0;
      rd_en         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (kind)
                  KIND_OBTAIN: begin
                     rsp_valid_in = 1'b1;
                     rsp_owner_in = '0;
                     rsp_last_in  = 1'b1;
                     if (any_free) begin
                        free_in[grant_idx] = 1'b0;
                        owner_we           = 1'b1;
                        rsp_kind_in        = RES_GRANTED;
                        rsp_handle_in      = HandleW'(grant_idx);
                     end else begin
                        rsp_kind_in   = RES_FULL;
                        rsp_handle_in = '0;
                     end
                  end
                  KIND_RELEASE: begin
                     if (h_ok) begin
                        free_in[hidx] = 1'b1;
                        wait_in[hidx] = 1'b0;
                     end
                  end
                  KIND_ARM: begin
                     if (h_ok && !free_ff[hidx]) begin
                        wait_in[hidx] = 1'b1;
                        time_we       = 1'b1;
                     end
                  end
                  KIND_TICK: begin
                     time_now_in = time_now_ff + 1'b1;
                     idx_in      = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            rd_en = 1'b1;
         end
         ST_CHECK: begin
            if (hit && out_free) begin
               wait_in[idx_ff] = 1'b0;
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = RES_NOTICE;
               rsp_handle_in   = HandleW'(idx_ff);
               rsp_owner_in    = owner_rdata;
               rsp_last_in     = 1'b0;
            end
            if (!(hit && !out_free) && idx_ff != LastIdx) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = RES_DONE;
               rsp_handle_in = '0;
               rsp_owner_in  = '0;
               rsp_last_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         time_now_ff  <= '0;
         timeout_ff   <= TimeoutReset;
         free_ff      <= '1;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         time_now_ff  <= time_now_in;
         free_ff      <= free_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_handle_res  = rsp_handle_ff;
   assign rsp_owner_res   = rsp_owner_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire
